// ===== design/assert_macros.svh =====
// Assertion macros shared by the cache modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

// ===== design/lrukv_pkg.sv =====
// Shared types and constants of the LRU write-back key/value cache.
package lrukv_pkg;
  localparam int DEF_ENTRIES = 16;
  localparam int DEF_KEY_BITS = 64;
  localparam int DEF_VALUE_BITS = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] FUNC_GET = 2'd0;
  localparam logic [1:0] FUNC_SET = 2'd1;
  localparam logic [1:0] FUNC_FILL = 2'd2;
  localparam logic [1:0] FUNC_FLUSH = 2'd3;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_FETCH = 2'd1;
  localparam logic [1:0] KIND_WB = 2'd2;
  localparam logic [1:0] KIND_ACK = 2'd3;

  localparam logic [1:0] REG_CAPACITY = 2'd0;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOK, ST_EVICT, ST_INSERT, ST_FLUSH, ST_EMIT
  } state_t;

  // Classified command handed from front to back.
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic [63:0] data;
    logic        found;
  } cmd_t;
endpackage

// ===== design/lrukv_front.sv =====
// Front end: accepts input transactions, masks fields and queues commands.
module lrukv_front #(
  parameter int KEY_BITS = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       func,
  input  logic [63:0]      key,
  input  logic [63:0]      data_in,
  input  logic             fill_found,
  output lrukv_pkg::cmd_t  q_cmd,
  output logic             q_valid,
  input  logic             q_take
);
  import lrukv_pkg::*;
  `include "assert_macros.svh"

  localparam logic [63:0] KMASK = {64{1'b1}} >> (64 - KEY_BITS);
  localparam logic [63:0] VMASK = {64{1'b1}} >> (64 - VALUE_BITS);
  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t           mem [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    count;
  logic           push, pop;

  assign in_stall = (count == PW'(0) + (PW+1)'(QUEUE_DEPTH));
  assign push = in_valid && !in_stall;
  assign pop = q_take && q_valid;
  assign q_valid = (count != '0);
  assign q_cmd = mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{func: func, key: key & KMASK, data: data_in & VMASK,
                       found: fill_found};
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= PW'((wr_ptr + 1'b1) % QUEUE_DEPTH);
      if (pop) rd_ptr <= PW'((rd_ptr + 1'b1) % QUEUE_DEPTH);
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  `ASSERT_CLK(a_no_overflow, clk, rst, count <= (PW+1)'(QUEUE_DEPTH), "queue overflow")
  `ASSERT_CLK(a_pop_valid, clk, rst, pop |-> count != '0, "pop of empty queue")
  `ASSERT_CLK(a_count_step, clk, rst, (push && !pop) |=> count == $past(count) + 1'b1,
              "queue count slip")
endmodule

// ===== design/lrukv_back.sv =====
// Back end: tag lookup, LRU update, eviction, insert and flush sequencing.
module lrukv_back #(
  parameter int ENTRIES = 16,
  parameter int KEY_BITS = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  lrukv_pkg::cmd_t q_cmd,
  input  logic            q_valid,
  output logic            q_take,
  input  logic [4:0]      capacity,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      kind,
  output logic [63:0]     key_out,
  output logic [63:0]     data_out,
  output logic            status,
  output logic            last
);
  import lrukv_pkg::*;
  `include "assert_macros.svh"

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [63:0]   skey [ENTRIES];
  logic [63:0]   sval [ENTRIES];
  logic [ENTRIES-1:0] valid, dirty;
  logic [IW-1:0] age [ENTRIES];
  logic [CW-1:0] count;

  state_t        state, state_next;
  cmd_t          cmd;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [CW-1:0] rank;
  logic [CW-1:0] cap;

  // Output register fields.
  logic [1:0]    o_kind;
  logic [63:0]   o_key, o_data;
  logic          o_status, o_last, o_full;

  // Combinational selects.
  logic          m_hit;
  logic [IW-1:0] m_idx;
  logic          r_found;
  logic [IW-1:0] r_idx;
  logic          f_free;
  logic [IW-1:0] f_idx;
  logic          out_free;
  logic          o_load;

  assign out_free = !o_full || !out_stall;
  assign out_valid = o_full;
  assign kind = o_kind;
  assign key_out = o_key;
  assign data_out = o_data;
  assign status = o_status;
  assign last = o_last;
  assign q_take = (state == ST_IDLE) && q_valid;

  // Effective capacity clamp.
  always_comb begin
    if (capacity == 5'd0) cap = CW'(1);
    else if (32'(capacity) > ENTRIES) cap = CW'(ENTRIES);
    else cap = CW'(capacity);
  end

  // Parallel tag match, rank search and free slot search.
  always_comb begin
    m_hit = 1'b0; m_idx = '0;
    r_found = 1'b0; r_idx = '0;
    f_free = 1'b0; f_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid[i] && skey[i] == cmd.key && !m_hit) begin
        m_hit = 1'b1; m_idx = IW'(i);
      end
      if (valid[i] && CW'(age[i]) == rank && !r_found) begin
        r_found = 1'b1; r_idx = IW'(i);
      end
      if (!valid[i] && !f_free) begin
        f_free = 1'b1; f_idx = IW'(i);
      end
    end
  end

  // A new result enters the output register this cycle.
  always_comb begin
    o_load = 1'b0;
    case (state)
      ST_EVICT: o_load = count >= cap && count != '0 && out_free && r_found && dirty[r_idx];
      ST_FLUSH: o_load = rank < count && out_free && r_found && dirty[r_idx];
      ST_EMIT: o_load = out_free;
      default: o_load = 1'b0;
    endcase
  end

  // Output register occupancy.
  always_ff @(posedge clk) begin
    if (rst) o_full <= 1'b0;
    else if (o_load) o_full <= 1'b1;
    else if (!out_stall) o_full <= 1'b0;
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid) state_next = ST_LOOK;
      ST_LOOK: begin
        case (cmd.func)
          FUNC_FLUSH: state_next = ST_FLUSH;
          FUNC_SET: state_next = m_hit ? ST_EMIT : ST_EVICT;
          FUNC_FILL: state_next = (m_hit || !cmd.found) ? ST_EMIT : ST_EVICT;
          default: state_next = ST_EMIT;
        endcase
      end
      ST_EVICT: if (!(count >= cap && count != '0)) state_next = ST_INSERT;
      ST_INSERT: state_next = ST_EMIT;
      ST_FLUSH: if (rank >= count) state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and cache state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      dirty <= '0;
      count <= '0;
      for (int i = 0; i < ENTRIES; i++) age[i] <= '0;
    end else begin
      case (state)
        ST_IDLE: if (q_valid) cmd <= q_cmd;
        ST_LOOK: begin
          hit <= m_hit;
          hit_idx <= m_idx;
          rank <= (cmd.func == FUNC_FLUSH) ? '0 : count - 1'b1;
          if (m_hit && cmd.func != FUNC_FLUSH) begin
            for (int i = 0; i < ENTRIES; i++)
              if (valid[i] && age[i] < age[m_idx]) age[i] <= age[i] + 1'b1;
            age[m_idx] <= '0;
            if (cmd.func == FUNC_SET) begin
              sval[m_idx] <= cmd.data;
              dirty[m_idx] <= 1'b1;
            end
          end
        end
        ST_EVICT: begin
          if (count >= cap && count != '0 && out_free) begin
            if (r_found) begin
              valid[r_idx] <= 1'b0;
              dirty[r_idx] <= 1'b0;
              age[r_idx] <= '0;
              if (dirty[r_idx]) begin
                o_kind <= KIND_WB; o_key <= skey[r_idx];
                o_data <= sval[r_idx]; o_status <= 1'b0; o_last <= 1'b0;
              end
            end
            count <= count - 1'b1;
            rank <= count - 2'd2;
          end
        end
        ST_INSERT: begin
          for (int i = 0; i < ENTRIES; i++)
            if (valid[i]) age[i] <= age[i] + 1'b1;
          if (f_free) begin
            skey[f_idx] <= cmd.key;
            sval[f_idx] <= cmd.data;
            valid[f_idx] <= 1'b1;
            dirty[f_idx] <= (cmd.func == FUNC_SET);
            age[f_idx] <= '0;
            count <= count + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (rank < count && out_free) begin
            if (r_found && dirty[r_idx]) begin
              dirty[r_idx] <= 1'b0;
              o_kind <= KIND_WB; o_key <= skey[r_idx];
              o_data <= sval[r_idx]; o_status <= 1'b0; o_last <= 1'b0;
            end
            rank <= rank + 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            o_last <= 1'b1; o_status <= 1'b0;
            o_key <= cmd.key; o_data <= '0;
            case (cmd.func)
              FUNC_GET: begin
                o_kind <= hit ? KIND_REPLY : KIND_FETCH;
                if (hit) o_data <= sval[hit_idx];
              end
              FUNC_SET: o_kind <= KIND_ACK;
              FUNC_FILL: begin
                o_kind <= KIND_REPLY;
                if (hit) o_data <= sval[hit_idx];
                else if (cmd.found) o_data <= cmd.data;
                else o_status <= 1'b1;
              end
              default: begin
                o_kind <= KIND_ACK;
                o_key <= '0;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_CLK(a_count_cap, clk, rst, count <= CW'(ENTRIES), "entry count over depth")
  `ASSERT_CLK(a_count_valid, clk, rst, state == ST_IDLE |-> $countones(valid) == 32'(count),
              "count disagrees with valid bits")
  `ASSERT_CLK(a_dirty_valid, clk, rst, (dirty & ~valid) == '0, "dirty slot not valid")
  `ASSERT_CLK(a_out_hold, clk, rst, (o_full && out_stall) |=> $stable(o_key) && o_full,
              "stalled result changed")
endmodule

// ===== design/lru_writeback_kv_cache.sv =====
// Top level of the LRU write-back key/value cache.
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | func, key, data_in, fill_found
//  out     | output    | out_valid / out_stall| kind, key_out, data_out, status, last
//  cfg     | input     | APB psel / penable   | capacity at address 0
// A get or a hit passes the back end steps queue pop, parallel tag match and result, in that order.
// Inserts add the eviction check, which evicts entries until there is room, and then the insert.
// Flush walks the recency ranks of the live entries, writing back dirty ones, then acknowledges.
// Reset is synchronous and clears all valid, dirty and age state.
// A stalled result holds the back end; the input queue keeps accepting until full.
module lru_writeback_kv_cache #(
  parameter int ENTRIES = lrukv_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lrukv_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lrukv_pkg::DEF_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [63:0] key,
  input  logic [63:0] data_in,
  input  logic        fill_found,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [63:0] key_out,
  output logic [63:0] data_out,
  output logic        status,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lrukv_pkg::*;

  cmd_t       q_cmd;
  logic       q_valid, q_take;
  logic [4:0] capacity;

  assign pready = 1'b1;
  assign prdata = (paddr == {REG_CAPACITY[1:0]}) ? {27'd0, capacity} : 32'd0;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) capacity <= 5'd16;
    else if (psel && penable && pwrite && paddr == REG_CAPACITY) capacity <= pwdata[4:0];
  end

  lrukv_front #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .func, .key, .data_in, .fill_found,
    .q_cmd, .q_valid, .q_take
  );

  lrukv_back #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .q_cmd, .q_valid, .q_take, .capacity,
    .out_valid, .out_stall, .kind, .key_out, .data_out, .status, .last
  );
endmodule
